@@ sv/sra_pkg.sv @@
// Shared types and constants for the sequence range add/reverse unit.
// No dependencies.
package sra_pkg;
   localparam int unsigned IDX_W = 11;
   localparam int unsigned DATA_W = 32;
   // segment size of the split-and-rebuild bookkeeping; flat storage does not need it
   localparam int unsigned SEGMENT_SIZE = 32;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_ADD   = 2'd1,
      OP_REV   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [0:0] REG_LENGTH = 1'b0;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [IDX_W-1:0]  first_index;
      logic [IDX_W-1:0]  end_index;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              status;
   } rsp_type;
endpackage

@@ sv/sra_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on sra_pkg for payload widths.
interface sra_req_if;
   logic             valid;
   logic             ready;
   sra_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sra_rsp_if;
   logic             valid;
   logic             ready;
   sra_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/sequence_range_add_reverse_unit.sv @@
// Sequence range add/reverse unit: top level with sequencer and shared adder.
// Depends on sra_pkg, sra_if, sra_mem.
// Error or empty range: straight to S_RESP. Write: S_RD. Read: S_RD, S_WAIT. Add:
// S_RD, S_WAIT, S_ADDW per element. Reverse: S_RD, S_WAIT, S_SWAP_RD2, S_SWAP_W1,
// S_SWAP_W2 per swapped pair. One transaction in flight: req ready only while idle,
// not until the response is taken. Synchronous reset clears control and length, not RAM.
module sequence_range_add_reverse_unit #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic clock,
   input  logic reset,
   sra_req_if.sink   req,
   sra_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned IW = sra_pkg::IDX_W;
   // Capacity clamp; capacity above the index range saturates the compare.
   localparam logic [IW:0] CAP = (CAPACITY >= (1 << IW)) ? (IW+1)'((1 << IW))
                                                         : (IW+1)'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_WAIT, S_ADDW, S_SWAP_RD2, S_SWAP_W1, S_SWAP_W2, S_RESP
   } state_type;

   state_type         state_ff;
   logic [IW-1:0]     length_ff;
   logic [1:0]        op_ff;
   logic [IW-1:0]     lo_ff, hi_ff;
   logic [31:0]       val_ff, tmp_ff, rdv_ff;
   logic              status_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [31:0]       mem_wdata, mem_rdata;
   logic [IW:0]       eff_len;

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-IW){1'b0}}, length_ff};
   assign eff_len = ({1'b0, length_ff} > CAP) ? CAP : {1'b0, length_ff};

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.payload.read_value = rdv_ff;
   assign rsp.payload.status = status_ff;

   sra_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
      .clock(clock), .we(mem_we), .addr(mem_addr),
      .wdata(mem_wdata), .rdata(mem_rdata)
   );

   // RAM port steering: one access per cycle
   always_comb begin
      mem_we = 1'b0;
      mem_addr = AW'(lo_ff);
      mem_wdata = val_ff;
      case (state_ff)
         S_RD: begin
            mem_we = (op_ff == sra_pkg::OP_WRITE);   // element write
         end
         S_ADDW: begin
            mem_we = 1'b1;
            mem_wdata = mem_rdata + val_ff;   // the shared adder
         end
         S_SWAP_RD2: mem_addr = AW'(hi_ff);
         S_SWAP_W1: begin
            mem_we = 1'b1;
            mem_wdata = mem_rdata;            // hi value into lo
         end
         S_SWAP_W2: begin
            mem_we = 1'b1;
            mem_addr = AW'(hi_ff);
            mem_wdata = tmp_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         length_ff <= '0;
         status_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1] == 1'b0 &&
             csr_paddr[0] == sra_pkg::REG_LENGTH) begin
            length_ff <= csr_pwdata[IW-1:0];
         end
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               op_ff <= req.payload.opcode;
               lo_ff <= req.payload.first_index;
               hi_ff <= req.payload.end_index - IW'(1);
               val_ff <= req.payload.value;
               rdv_ff <= '0;
               status_ff <= 1'b0;
               state_ff <= S_RESP;
               if (req.payload.opcode == sra_pkg::OP_WRITE ||
                   req.payload.opcode == sra_pkg::OP_READ) begin
                  if ({1'b0, req.payload.first_index} >= eff_len) begin
                     status_ff <= 1'b1;
                  end else begin
                     state_ff <= S_RD;   // write done in S_RD, read waits
                  end
               end else if (req.payload.first_index > req.payload.end_index ||
                            {1'b0, req.payload.end_index} > eff_len) begin
                  status_ff <= 1'b1;
               end else if (req.payload.first_index != req.payload.end_index)
               begin
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               // address lo presented; for a write, write happens here
               if (op_ff == sra_pkg::OP_WRITE) state_ff <= S_RESP;
               else state_ff <= S_WAIT;
            end
            S_WAIT: begin
               unique case (op_ff)
                  sra_pkg::OP_READ: begin
                     rdv_ff <= mem_rdata;
                     state_ff <= S_RESP;
                  end
                  sra_pkg::OP_ADD: state_ff <= S_ADDW;
                  default: begin
                     tmp_ff <= mem_rdata;
                     state_ff <= (lo_ff < hi_ff) ? S_SWAP_RD2 : S_RESP;
                  end
               endcase
            end
            S_ADDW: begin
               if (lo_ff + IW'(1) > hi_ff) state_ff <= S_RESP;
               else begin
                  lo_ff <= lo_ff + IW'(1);
                  state_ff <= S_RD;
               end
            end
            S_SWAP_RD2: state_ff <= S_SWAP_W1;
            S_SWAP_W1: state_ff <= S_SWAP_W2;
            S_SWAP_W2: begin
               lo_ff <= lo_ff + IW'(1);
               hi_ff <= hi_ff - IW'(1);
               state_ff <= S_RD;
            end
            S_RESP: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ sv/sra_mem.sv @@
// Element store: single-port RAM, one write and one registered read (old data) a cycle.
// Depends on nothing but its parameters.
module sra_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW = 10
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wdata,
   output logic [31:0]   rdata
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

@@ sv/sra_checker.sv @@
// Port-level checker for sequence_range_add_reverse_unit, with bind.
// Depends on the top level's port list only.
module sra_props (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_pready
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accepted while busy");
   a_prdy: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind sequence_range_add_reverse_unit sra_props u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .csr_pready(csr_pready)
);
